@@ hdl/ems_pkg.sv @@
// Shared widths, defaults and the pipeline stage record for the ECMP member select block.
`timescale 1ns / 1ps

package ems_pkg;

    localparam int HASH_W     = 16;
    localparam int MASK_W     = 32;
    localparam int LEN_W      = 5;
    localparam int BASE_W     = 20;
    localparam int IDX_W      = 5;
    localparam int CNT_W      = 6;

    localparam int DEF_ADDR_BITS   = 20;
    localparam int DEF_MAX_MEMBERS = 32;

    // Remainder units retire this many hash bits per stage.
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = HASH_W / MOD_BITS;

    typedef struct packed {
        logic [HASH_W-1:0]            hash;
        logic [MASK_W-1:0]            members;
        logic [MASK_W-1:0][IDX_W-1:0] prefix;
        logic [CNT_W-1:0]             ones;
        logic [CNT_W-1:0]             count;
        logic [IDX_W-1:0]             rem_c;
        logic [IDX_W-1:0]             rem_o;
        logic                         empty;
        logic [IDX_W-1:0]             idx;
        logic [BASE_W-1:0]            base;
    } t_stage;

endpackage

@@ hdl/ems_mod_step.sv @@
// Restoring remainder slice: folds a few hash bits into a running remainder.
`timescale 1ns / 1ps

module ems_mod_step (
    input  logic [ems_pkg::IDX_W-1:0]    i_rem,
    input  logic [ems_pkg::CNT_W-1:0]    i_div,
    input  logic [ems_pkg::MOD_BITS-1:0] i_bits,
    output logic [ems_pkg::IDX_W-1:0]    o_rem
);

    always_comb begin
        logic [ems_pkg::CNT_W-1:0] r;
        r = {1'b0, i_rem};
        for (int b = ems_pkg::MOD_BITS - 1; b >= 0; b--) begin
            r = {r[ems_pkg::IDX_W-1:0], i_bits[b]};
            if (r >= i_div) begin
                r = r - i_div;
            end
        end
        o_rem = r[ems_pkg::IDX_W-1:0];
    end

endmodule

@@ hdl/ecmp_member_select.sv @@
// Top level of the ECMP member select pipeline.
// Throughput: one request per cycle while i_stall is low; stall is absorbed stage by stage, so bubbles close up.
// Stages: mask and prefix counts, four remainder stages, member pick, address add.
// Reset: synchronous, active low; clears the stage valid bits only.
`timescale 1ns / 1ps

module ecmp_member_select #(
    parameter int ADDR_BITS   = ems_pkg::DEF_ADDR_BITS,
    parameter int MAX_MEMBERS = ems_pkg::DEF_MAX_MEMBERS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ems_pkg::HASH_W-1:0]   i_hash_value,
    input  logic [ems_pkg::MASK_W-1:0]   i_member_mask,
    input  logic [ems_pkg::LEN_W-1:0]    i_group_length,
    input  logic [ems_pkg::BASE_W-1:0]   i_base_address,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ADDR_BITS-1:0]         o_selected_address,
    output logic [ems_pkg::IDX_W-1:0]    o_member_index,
    output logic                         o_no_members
);

    localparam int NST  = ems_pkg::MOD_STEPS + 2;  // stages holding a stage record
    localparam int NV   = NST + 1;                 // plus the output stage
    localparam int EXTW = 33;

    ems_pkg::t_stage r_st [0:NST-1];
    ems_pkg::t_stage n_st [0:NST-1];
    logic [NV-1:0]   r_v;
    logic [NV:0]     mv;

    logic [ADDR_BITS-1:0]      r_addr;
    logic [ems_pkg::IDX_W-1:0] r_idx;
    logic                      r_none;

    logic [ems_pkg::IDX_W-1:0] rem_c_nx [1:ems_pkg::MOD_STEPS];
    logic [ems_pkg::IDX_W-1:0] rem_o_nx [1:ems_pkg::MOD_STEPS];
    logic [ems_pkg::MASK_W-1:0] sel;
    logic [ADDR_BITS-1:0]       n_addr;

    // A stage may load when it is empty or its contents move on.
    always_comb begin
        mv[NV] = ~i_stall;
        for (int k = NV - 1; k >= 0; k--) begin
            mv[k] = ~r_v[k] | mv[k+1];
        end
    end

    assign o_stall = ~mv[0];

    // Stage 0: clamp length, mask members, prefix counts.
    always_comb begin
        logic [ems_pkg::LEN_W-1:0]  len_c;
        logic [ems_pkg::MASK_W-1:0] masked;
        len_c = (i_group_length > ems_pkg::LEN_W'(MAX_MEMBERS - 1))
              ? ems_pkg::LEN_W'(MAX_MEMBERS - 1) : i_group_length;
        for (int i = 0; i < ems_pkg::MASK_W; i++) begin
            masked[i] = i_member_mask[i] && (ems_pkg::LEN_W'(i) <= len_c);
        end
        n_st[0]         = '0;
        n_st[0].hash    = i_hash_value;
        n_st[0].members = masked;
        for (int i = 0; i < ems_pkg::MASK_W; i++) begin
            n_st[0].prefix[i] =
                ems_pkg::IDX_W'($countones(masked & ((ems_pkg::MASK_W'(1) << i) - 1'b1)));
        end
        n_st[0].ones  = ems_pkg::CNT_W'($countones(masked));
        n_st[0].count = {1'b0, len_c} + 1'b1;
        n_st[0].empty = (masked == '0);
        n_st[0].base  = i_base_address;
    end

    // Stages 1..MOD_STEPS: both remainders advance a few hash bits, most significant first.
    for (genvar g = 1; g <= ems_pkg::MOD_STEPS; g++) begin : g_mod
        localparam int TOP = ems_pkg::HASH_W - 1 - (g - 1) * ems_pkg::MOD_BITS;

        ems_mod_step u_mod_c (
            .i_rem  (r_st[g-1].rem_c),
            .i_div  (r_st[g-1].count),
            .i_bits (r_st[g-1].hash[TOP -: ems_pkg::MOD_BITS]),
            .o_rem  (rem_c_nx[g])
        );

        ems_mod_step u_mod_o (
            .i_rem  (r_st[g-1].rem_o),
            .i_div  (r_st[g-1].ones),
            .i_bits (r_st[g-1].hash[TOP -: ems_pkg::MOD_BITS]),
            .o_rem  (rem_o_nx[g])
        );

        always_comb begin
            n_st[g]       = r_st[g-1];
            n_st[g].rem_c = rem_c_nx[g];
            n_st[g].rem_o = rem_o_nx[g];
        end
    end

    // Pick stage: index 0 for an empty group, else direct hit, else the k-th enabled member.
    always_comb begin
        logic [ems_pkg::IDX_W-1:0] enc;
        enc = '0;
        for (int i = 0; i < ems_pkg::MASK_W; i++) begin
            sel[i] = r_st[NST-2].members[i] && (r_st[NST-2].prefix[i] == r_st[NST-2].rem_o);
            if (sel[i]) begin
                enc = enc | ems_pkg::IDX_W'(i);
            end
        end
        n_st[NST-1] = r_st[NST-2];
        if (r_st[NST-2].empty) begin
            n_st[NST-1].idx = '0;
        end else if (r_st[NST-2].members[r_st[NST-2].rem_c]) begin
            n_st[NST-1].idx = r_st[NST-2].rem_c;
        end else begin
            n_st[NST-1].idx = enc;
        end
    end

    // Address stage: wrap base plus index at the address width.
    always_comb begin
        logic [EXTW-1:0] base_ext;
        base_ext = {{(EXTW - ems_pkg::BASE_W){1'b0}}, r_st[NST-1].base};
        n_addr   = base_ext[ADDR_BITS-1:0]
                 + {{(ADDR_BITS - ems_pkg::IDX_W){1'b0}}, r_st[NST-1].idx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k < NV; k++) begin
                if (mv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (mv[0]) begin
                r_v[0] <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (mv[k]) begin
                r_st[k] <= n_st[k];
            end
        end
        if (mv[NV-1]) begin
            r_addr <= n_addr;
            r_idx  <= r_st[NST-1].idx;
            r_none <= r_st[NST-1].empty;
        end
    end

    assign o_valid            = r_v[NV-1];
    assign o_selected_address = r_addr;
    assign o_member_index     = r_idx;
    assign o_no_members       = r_none;

`ifndef NO_ASSERTIONS
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v[0])
        else $error("input stalled while first stage is empty");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NST-2] |-> ({1'b0, r_st[NST-2].rem_c} < r_st[NST-2].count))
        else $error("member remainder not below group size");

    a_pick_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-2] && !r_st[NST-2].empty) |-> $onehot(sel))
        else $error("fallback pick is not a single member");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_member_index <= ems_pkg::IDX_W'(MAX_MEMBERS - 1)))
        else $error("member index beyond group limit");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_members) |-> (o_member_index == '0))
        else $error("empty group gave a nonzero index");
`endif

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the ECMP member select pipeline.
`timescale 1ns / 1ps

module tb;
    import ems_pkg::*;

    localparam int ADDR_BITS    = DEF_ADDR_BITS;
    localparam int MAX_MEMBERS  = DEF_MAX_MEMBERS;
    localparam int RANDOM_COUNT = 700;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_LIMIT   = 2000;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [IDX_W-1:0]     idx;
        logic                 none;
    } t_pick;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [MASK_W-1:0] mask;
        logic [LEN_W-1:0]  len;
        logic [BASE_W-1:0] base;
        logic              typed;
        t_pick             want;
    } t_request;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [HASH_W-1:0]    i_hash_value;
    logic [MASK_W-1:0]    i_member_mask;
    logic [LEN_W-1:0]     i_group_length;
    logic [BASE_W-1:0]    i_base_address;
    logic                 o_valid;
    logic                 i_stall;
    logic [ADDR_BITS-1:0] o_selected_address;
    logic [IDX_W-1:0]     o_member_index;
    logic                 o_no_members;

    t_request stim_q[$];
    t_pick    pick_q[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       hold_req = 1'b0;
    bit       no_idle = 1'b0;

    ecmp_member_select #(
        .ADDR_BITS   (ADDR_BITS),
        .MAX_MEMBERS (MAX_MEMBERS)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_hash_value       (i_hash_value),
        .i_member_mask      (i_member_mask),
        .i_group_length     (i_group_length),
        .i_base_address     (i_base_address),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_selected_address (o_selected_address),
        .o_member_index     (o_member_index),
        .o_no_members       (o_no_members)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Expected member pick for one request.
    function automatic t_pick select_member(input logic [HASH_W-1:0] hash,
                                            input logic [MASK_W-1:0] mask,
                                            input logic [LEN_W-1:0] len,
                                            input logic [BASE_W-1:0] base);
        t_pick        p;
        logic [31:0]  live;
        int unsigned  span;
        int unsigned  ones;
        int unsigned  k;
        int unsigned  idx;
        span = (len > MAX_MEMBERS - 1) ? MAX_MEMBERS : len + 1;
        live = mask;
        if (span < 32) begin
            live = live & ((32'h1 << span) - 32'h1);
        end
        p.none = 1'b0;
        if (live == 32'h0) begin
            p.addr = base[ADDR_BITS-1:0];
            p.idx  = '0;
            p.none = 1'b1;
            return p;
        end
        idx = hash % span;
        if (!live[idx]) begin
            ones = $countones(live);
            k    = hash % ones;
            for (int b = 0; b < 32; b++) begin
                if (live[b]) begin
                    if (k == 0) begin
                        idx = b;
                        break;
                    end
                    k--;
                end
            end
        end
        p.addr = base[ADDR_BITS-1:0] + idx[ADDR_BITS-1:0];
        p.idx  = idx[IDX_W-1:0];
        return p;
    endfunction

    task automatic add_request(input logic [HASH_W-1:0] hash, input logic [MASK_W-1:0] mask,
                               input logic [LEN_W-1:0] len, input logic [BASE_W-1:0] base,
                               input logic typed, input logic [ADDR_BITS-1:0] addr,
                               input logic [IDX_W-1:0] idx, input logic none);
        t_request r;
        r.hash      = hash;
        r.mask      = mask;
        r.len       = len;
        r.base      = base;
        r.typed     = typed;
        r.want.addr = addr;
        r.want.idx  = idx;
        r.want.none = none;
        stim_q.push_back(r);
    endtask

    function automatic t_request random_request();
        t_request    r;
        logic [31:0] w;
        int unsigned style;
        w = $urandom;
        r.hash = ($urandom_range(0, 4) == 0) ? HASH_W'($urandom_range(0, 63)) : w[HASH_W-1:0];
        style = $urandom_range(0, 19);
        case (style)
            0:       r.mask = 32'h0;
            1, 2:    r.mask = 32'hFFFF_FFFF;
            3, 4:    r.mask = 32'h1 << $urandom_range(0, 31);
            5, 6, 7: r.mask = $urandom & $urandom & $urandom;
            8, 9:    r.mask = $urandom | $urandom;
            10:      r.mask = ~(32'h1 << $urandom_range(0, 31));
            default: r.mask = $urandom;
        endcase
        style = $urandom_range(0, 3);
        case (style)
            0:       r.len = LEN_W'(31);
            1:       r.len = LEN_W'($urandom_range(0, 7));
            default: r.len = LEN_W'($urandom_range(0, 31));
        endcase
        w = $urandom;
        if ($urandom_range(0, 4) == 0) begin
            r.base = BASE_W'(20'hFFFFF - $urandom_range(0, 31));
        end else begin
            r.base = w[BASE_W-1:0];
        end
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic log_mismatch(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("tb: %s mismatch at %0t: expected 0x%0h, got 0x%0h",
                     what, $time, want_v, got_v);
        end
    endtask

    // Request side.
    initial begin : sender
        t_request r;
        t_pick    p;
        int       gap;
        int       burst;
        int       n;
        int       n_directed;
        bit       pause;
        i_valid        <= 1'b0;
        i_hash_value   <= '0;
        i_member_mask  <= '0;
        i_group_length <= '0;
        i_base_address <= '0;

        // Typed rows: empty groups, full groups, wrap of the address, single members.
        add_request(16'hFFFF, 32'h0000_0000, 5'd31, 20'hFFFFF, 1'b1, 20'hFFFFF, 5'd0,  1'b1);
        add_request(16'h0000, 32'h0000_0000, 5'd0,  20'h00000, 1'b1, 20'h00000, 5'd0,  1'b1);
        add_request(16'h1234, 32'hFFFF_FFFE, 5'd0,  20'hABCDE, 1'b1, 20'hABCDE, 5'd0,  1'b1);
        add_request(16'h5A5A, 32'h8000_0000, 5'd30, 20'h54321, 1'b1, 20'h54321, 5'd0,  1'b1);
        add_request(16'hFFFF, 32'hFFFF_FFFF, 5'd31, 20'h00000, 1'b1, 20'h0001F, 5'd31, 1'b0);
        add_request(16'h001F, 32'hFFFF_FFFF, 5'd31, 20'hFFFFF, 1'b1, 20'h0001E, 5'd31, 1'b0);
        add_request(16'hFFFF, 32'h0000_0001, 5'd0,  20'h12345, 1'b1, 20'h12345, 5'd0,  1'b0);
        add_request(16'h0000, 32'h8000_0000, 5'd31, 20'h00001, 1'b1, 20'h00020, 5'd31, 1'b0);
        add_request(16'h0000, 32'h0000_0001, 5'd31, 20'hFFFFF, 1'b1, 20'hFFFFF, 5'd0,  1'b0);
        // Fallback to the n-th enabled member and bits above the length.
        add_request(16'h0004, 32'hAAAA_AAAA, 5'd31, 20'h00100, 1'b0, '0, '0, 1'b0);
        add_request(16'hFFFF, 32'h5555_5555, 5'd31, 20'hFFFF0, 1'b0, '0, '0, 1'b0);
        add_request(16'h001F, 32'h7FFF_FFFF, 5'd31, 20'h00000, 1'b0, '0, '0, 1'b0);
        add_request(16'h0020, 32'hFFFF_FFFE, 5'd31, 20'h7FFFF, 1'b0, '0, '0, 1'b0);
        add_request(16'hFFFE, 32'h0000_0001, 5'd31, 20'h80000, 1'b0, '0, '0, 1'b0);
        add_request(16'h4321, 32'h8000_0001, 5'd31, 20'h0F0F0, 1'b0, '0, '0, 1'b0);
        add_request(16'hBEEF, 32'hFFFF_0000, 5'd15, 20'h33333, 1'b0, '0, '0, 1'b0);
        add_request(16'h0003, 32'h0001_0000, 5'd16, 20'hCCCCC, 1'b0, '0, '0, 1'b0);
        add_request(16'hFFFF, 32'h0001_FFFF, 5'd16, 20'hFFFFE, 1'b0, '0, '0, 1'b0);
        add_request(16'hFFFF, 32'hFFFF_FFFF, 5'd7,  20'hFFFFF, 1'b0, '0, '0, 1'b0);
        add_request(16'h8000, 32'hDEAD_BEEF, 5'd20, 20'h80000, 1'b0, '0, '0, 1'b0);
        n_directed = stim_q.size();
        repeat (RANDOM_COUNT) stim_q.push_back(random_request());

        burst = 0;
        n = 0;
        wait (i_rst_n === 1'b1);
        while (stim_q.size() > 0) begin
            r = stim_q.pop_front();
            no_idle = (n >= n_directed + 350) && (n < n_directed + 450);
            gap = (burst > 0) ? 0 : idle_gap();
            pause = (n == n_directed) || (n == n_directed + 250);
            if (n > 0 && (gap > 0 || pause)) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            if (pause) wait (pick_q.size() == 0);
            repeat ((gap > 0) ? gap - 1 : 0) @(negedge i_clk);
            @(negedge i_clk);
            i_hash_value   <= r.hash;
            i_member_mask  <= r.mask;
            i_group_length <= r.len;
            i_base_address <= r.base;
            i_valid        <= 1'b1;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            p = r.typed ? r.want : select_member(r.hash, r.mask, r.len, r.base);
            pick_q.push_back(p);
            if (burst > 0) burst--;
            // Hold the result side off while requests keep coming back to back.
            if (n == n_directed + 100) begin
                hold_req = 1'b1;
                burst = 40;
            end
            n++;
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        no_idle = 1'b0;

        wait (pick_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatches += pick_q.size();
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Result side stall pattern.
    initial begin : receiver
        int open_len;
        int stall_len;
        i_stall <= 1'b0;
        forever begin
            open_len = no_idle ? 1 : $urandom_range(1, 12);
            repeat (open_len) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
            if (hold_req) begin
                stall_len = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall_len = idle_gap();
            end
            repeat (stall_len) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pick_q.size() == 0) begin
                log_mismatch("unrequested result", 32'h0, 32'(o_selected_address));
            end else begin
                want = pick_q.pop_front();
                if (o_selected_address !== want.addr) begin
                    log_mismatch("selected_address", 32'(want.addr), 32'(o_selected_address));
                end
                if (o_member_index !== want.idx) begin
                    log_mismatch("member_index", 32'(want.idx), 32'(o_member_index));
                end
                if (o_no_members !== want.none) begin
                    log_mismatch("no_members", 32'(want.none), 32'(o_no_members));
                end
            end
        end
    end

    // Watchdog: too long without any handshake on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

endmodule

@@ sim.f @@
hdl/ems_pkg.sv
hdl/ems_mod_step.sv
hdl/ecmp_member_select.sv
bench/tb.sv
